FILE: rtl/mats_pkg.sv
// shared types and constants for the multicolour ant torus step block
`default_nettype none

package mats_pkg;

  // grid geometry
  localparam int GridSide  = 64;
  localparam int CoordW    = 6;
  localparam int AddrW     = 2 * CoordW;
  localparam int GridDepth = GridSide * GridSide;
  localparam int CenterPos = GridSide / 2;

  // cell states and rule registers
  localparam int CellW     = 6;
  localparam int MaxStates = 64;
  localparam int LenW      = 7;
  localparam int RuleW     = 64;
  localparam int CfgIdxW   = 1;

  // stream payload widths
  localparam int InDataW  = 16;
  localparam int OutDataW = 24;

  typedef logic [CoordW-1:0] coord_t;
  typedef logic [CellW-1:0]  cell_t;
  typedef logic [AddrW-1:0]  addr_t;
  typedef logic [LenW-1:0]   len_t;

  typedef enum logic {
    CMD_STEP = 1'b0,
    CMD_READ = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    HEAD_NORTH = 2'd0,
    HEAD_EAST  = 2'd1,
    HEAD_SOUTH = 2'd2,
    HEAD_WEST  = 2'd3
  } heading_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TURN_RULE   = 1'b0,
    REG_RULE_LENGTH = 1'b1
  } reg_index_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_CALC = 1'b1
  } core_state_t;

  // request from the ant core to the grid memory
  typedef struct packed {
    logic  wr_en;
    addr_t wr_addr;
    cell_t wr_data;
    logic  rd_en;
    addr_t rd_addr;
  } mem_req_t;

  localparam coord_t CoordMax   = coord_t'(GridSide - 1);
  localparam coord_t CoordReset = coord_t'(CenterPos);
  localparam len_t   LenMax     = len_t'(MaxStates);

endpackage

`default_nettype wire

FILE: rtl/mats_grid_mem.sv
// grid cell memory with a clearing sweep after reset
`default_nettype none

module mats_grid_mem
  import mats_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire mem_req_t req,
  output cell_t         rd_data,
  output logic          clearing
);

  cell_t mem [GridDepth];
  addr_t clr_addr;

  // sweep every entry to zero once after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + addr_t'(1);
      if (clr_addr == addr_t'(GridDepth - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // write port, shared by the sweep and the ant core
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mats_core.sv
// ant state, step sequencer and result register
`default_nettype none

module mats_core
  import mats_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            clearing,
  input  wire logic [RuleW-1:0] turn_rule,
  input  wire len_t            rule_length,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire cmd_t            command,
  input  wire coord_t          read_x,
  input  wire coord_t          read_y,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output coord_t               ant_x,
  output coord_t               ant_y,
  output heading_t             heading,
  output cell_t                cell_value,
  output mem_req_t             req,
  input  wire cell_t           rd_data
);

  core_state_t state, state_next;
  coord_t      pos_x, pos_y;
  heading_t    facing;
  cmd_t        cmd_q;

  logic     accept;
  len_t     eff_len;
  len_t     cell_inc;
  cell_t    next_cell;
  heading_t facing_next;
  coord_t   pos_x_next, pos_y_next;

  // effective number of states, clamped to 1..MaxStates
  always_comb begin
    if (rule_length == '0) begin
      eff_len = len_t'(1);
    end else if (rule_length > LenMax) begin
      eff_len = LenMax;
    end else begin
      eff_len = rule_length;
    end
  end

  // new cell value and turn from the cell under the ant
  always_comb begin
    cell_inc  = len_t'(rd_data) + len_t'(1);
    next_cell = (cell_inc >= eff_len) ? '0 : cell_inc[CellW-1:0];
    if (turn_rule[rd_data]) begin
      facing_next = heading_t'(2'(facing + 2'd1));
    end else begin
      facing_next = heading_t'(2'(facing + 2'd3));
    end
  end

  // move one cell in the new heading, wrapping at the edges
  always_comb begin
    pos_x_next = pos_x;
    pos_y_next = pos_y;
    unique case (facing_next)
      HEAD_NORTH: pos_y_next = (pos_y == '0) ? CoordMax : pos_y - coord_t'(1);
      HEAD_EAST:  pos_x_next = (pos_x == CoordMax) ? '0 : pos_x + coord_t'(1);
      HEAD_SOUTH: pos_y_next = (pos_y == CoordMax) ? '0 : pos_y + coord_t'(1);
      HEAD_WEST:  pos_x_next = (pos_x == '0) ? CoordMax : pos_x - coord_t'(1);
      default:    pos_x_next = pos_x;
    endcase
  end

  // handshake, memory requests and next state
  always_comb begin
    in_ready    = (state == ST_IDLE) && !clearing && (!out_valid || out_ready);
    accept      = in_valid && in_ready;
    req.rd_en   = accept;
    req.rd_addr = (command == CMD_READ) ? {read_y, read_x} : {pos_y, pos_x};
    req.wr_en   = (state == ST_CALC) && (cmd_q == CMD_STEP);
    req.wr_addr = {pos_y, pos_x};
    req.wr_data = next_cell;
    state_next  = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_CALC;
      ST_CALC: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ant position and heading
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x  <= CoordReset;
      pos_y  <= CoordReset;
      facing <= HEAD_NORTH;
    end else if (state == ST_CALC && cmd_q == CMD_STEP) begin
      pos_x  <= pos_x_next;
      pos_y  <= pos_y_next;
      facing <= facing_next;
    end
  end

  // command held across the memory read
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= command;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_CALC) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CALC) begin
      if (cmd_q == CMD_STEP) begin
        ant_x      <= pos_x_next;
        ant_y      <= pos_y_next;
        heading    <= facing_next;
        cell_value <= next_cell;
      end else begin
        ant_x      <= pos_x;
        ant_y      <= pos_y;
        heading    <= facing;
        cell_value <= rd_data;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/multicolour_ant_torus_step_top.sv
// top level of the multicolour ant on a 64 x 64 torus
`default_nettype none

// Generalized Langton's ant on a 64 x 64 wrapping grid of 6-bit cell states.
// Each input beat is either a step (tuser = 0: turn by the rule bit of the
// cell under the ant, advance that cell, move one cell) or a read of the
// cell at (read_x, read_y) (tuser = 1); every beat yields one output beat
// with the ant's position and heading and the cell value. The grid memory
// entry is read when an item is accepted and updated in the calculate state,
// and no new item is taken before then, as the next step's address depends
// on this move. After reset the grid memory is cleared one entry per cycle,
// so no input is accepted until all 4096 entries are clear; register writes
// are taken meanwhile. Write the registers only while the block is idle.

module multicolour_ant_torus_step_top
  import mats_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // input stream
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,   // read_x[5:0], read_y[11:6], zero fill
  input  wire logic [0:0]          s_axis_tuser,   // command[0]
  // output stream
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata,   // ant_x[5:0], ant_y[11:6],
                                                   // heading[13:12], cell_value[19:14], zero fill
  // register writes
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [RuleW-1:0]    cfg_data
);

  logic [RuleW-1:0] turn_rule;
  len_t             rule_length;

  mem_req_t req;
  cell_t    rd_data;
  logic     clearing;

  coord_t   ant_x, ant_y;
  heading_t heading;
  cell_t    cell_value;

  // rule registers
  always_ff @(posedge clk) begin
    if (rst) begin
      turn_rule   <= RuleW'(2);
      rule_length <= len_t'(2);
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_TURN_RULE:   turn_rule   <= cfg_data;
        REG_RULE_LENGTH: rule_length <= cfg_data[LenW-1:0];
        default:         ;
      endcase
    end
  end

  mats_grid_mem u_grid_mem (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rd_data  (rd_data),
    .clearing (clearing)
  );

  mats_core u_core (
    .clk         (clk),
    .rst         (rst),
    .clearing    (clearing),
    .turn_rule   (turn_rule),
    .rule_length (rule_length),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .command     (cmd_t'(s_axis_tuser[0])),
    .read_x      (s_axis_tdata[CoordW-1:0]),
    .read_y      (s_axis_tdata[2*CoordW-1:CoordW]),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .ant_x       (ant_x),
    .ant_y       (ant_y),
    .heading     (heading),
    .cell_value  (cell_value),
    .req         (req),
    .rd_data     (rd_data)
  );

  // pack the result beat
  assign m_axis_tdata = {4'b0, cell_value, heading, ant_y, ant_x};

endmodule

`default_nettype wire

FILE: test/multicolour_ant_torus_step_top_test.sv
// self-checking testbench for the multicolour ant torus step block
`default_nettype none

module multicolour_ant_torus_step_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mats_pkg::*;

  localparam int ResetCycles = 12;
  localparam int IdleLimit   = 20000;
  localparam int HoldCycles  = 400;
  localparam int DrainCycles = 8;
  localparam int MaxReports  = 40;
  localparam int WalkItems   = 165;
  localparam int ReadPct     = 25;

  typedef enum int {
    READY_ALWAYS,
    READY_HALF,
    READY_MOSTLY,
    READY_PERIODIC
  } stall_mode_t;

  typedef struct packed {
    coord_t   x;
    coord_t   y;
    heading_t dir;
    cell_t    value;
  } ant_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;   // read_x[5:0], read_y[11:6], zero fill
  logic [0:0]          s_axis_tuser = '0;   // command[0]
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;        // ant_x[5:0], ant_y[11:6],
                                            // heading[13:12], cell_value[19:14], zero fill
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [RuleW-1:0]    cfg_data = '0;

  // predicted ant and grid state
  cell_t            grid_model [GridDepth];
  coord_t           ant_px;
  coord_t           ant_py;
  heading_t         ant_dir;
  logic [RuleW-1:0] rule_bits;
  len_t             rule_len_reg;

  ant_result_t expected_results [$];

  int errors      = 0;
  int idle_cycles = 0;
  int burst_left  = 0;
  bit gaps_on     = 1'b1;
  bit hold_request = 1'b0;

  multicolour_ant_torus_step_top uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // advance the predicted ant by one item and return the beat it should produce
  function automatic ant_result_t predict_ant(cmd_t cmd, coord_t rx, coord_t ry);
    ant_result_t r;
    addr_t       addr;
    cell_t       v;
    int          n;
    int          nxt;
    if (cmd == CMD_READ) begin
      r.value = grid_model[{ry, rx}];
    end else begin
      addr = {ant_py, ant_px};
      v = grid_model[addr];
      // length zero acts as one, anything past the state limit is clamped
      n = int'(rule_len_reg);
      if (n < 1) n = 1;
      if (n > MaxStates) n = MaxStates;
      if (rule_bits[v]) ant_dir = heading_t'(ant_dir + 2'd1);
      else ant_dir = heading_t'(ant_dir + 2'd3);
      // a cell already at or past the length also wraps to zero
      nxt = int'(v) + 1;
      if (nxt >= n) nxt = 0;
      grid_model[addr] = cell_t'(nxt);
      case (ant_dir)
        HEAD_NORTH: ant_py = (ant_py == '0) ? CoordMax : ant_py - 1'b1;
        HEAD_EAST:  ant_px = (ant_px == CoordMax) ? '0 : ant_px + 1'b1;
        HEAD_SOUTH: ant_py = (ant_py == CoordMax) ? '0 : ant_py + 1'b1;
        default:    ant_px = (ant_px == '0) ? CoordMax : ant_px - 1'b1;
      endcase
      r.value = cell_t'(nxt);
    end
    r.x = ant_px;
    r.y = ant_py;
    r.dir = ant_dir;
    return r;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      if (errors <= MaxReports)
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  // offer one beat, in bursts with random gaps between them
  task automatic send_item(cmd_t cmd, coord_t rx, coord_t ry);
    int gap;
    if (gaps_on && burst_left <= 0) begin
      gap = $urandom_range(0, 10);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {{(InDataW - 2 * CoordW){1'b0}}, ry, rx};
    do @(posedge clk); while (!s_axis_tready);
    expected_results.insert(expected_results.size(), predict_ant(cmd, rx, ry));
    burst_left--;
  endtask

  // stop offering beats and let every pending result come out
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [RuleW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_TURN_RULE:   rule_bits = data;
      REG_RULE_LENGTH: rule_len_reg = data[LenW-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_random_item();
    cmd_t   cmd;
    coord_t rx;
    coord_t ry;
    cmd = ($urandom_range(0, 99) < ReadPct) ? CMD_READ : CMD_STEP;
    rx = coord_t'($urandom);
    ry = coord_t'($urandom);
    // half the reads look at the trail around the ant
    if (cmd == CMD_READ && $urandom_range(0, 1) == 1) begin
      rx = ant_px + coord_t'($urandom_range(0, 6)) - coord_t'(3);
      ry = ant_py + coord_t'($urandom_range(0, 6)) - coord_t'(3);
    end
    send_item(cmd, rx, ry);
  endtask

  task automatic run_walk(int count);
    repeat (count) send_random_item();
  endtask

  // directed: the cleared grid, read at the corners and on toggling patterns
  task automatic test_cleared_grid_reads();
    send_item(CMD_READ, '0, '0);
    send_item(CMD_READ, CoordMax, CoordMax);
    send_item(CMD_READ, '0, CoordMax);
    send_item(CMD_READ, 6'd42, 6'd21);
    send_item(CMD_READ, 6'd21, 6'd42);
  endtask

  // directed: reset rule, plain two-state ant from the centre
  task automatic test_classic_steps();
    repeat (4) send_item(CMD_STEP, coord_t'($urandom), coord_t'($urandom));
    send_item(CMD_READ, CoordReset, CoordReset);
  endtask

  task automatic test_length_zero();
    wait_drain();
    write_reg(REG_TURN_RULE, 64'h5);
    write_reg(REG_RULE_LENGTH, '0);
    repeat (2) send_item(CMD_STEP, coord_t'($urandom), coord_t'($urandom));
  endtask

  // all ones in the length register, far past the state limit
  task automatic test_length_oversize();
    wait_drain();
    write_reg(REG_TURN_RULE, '1);
    write_reg(REG_RULE_LENGTH, '1);
    repeat (2) send_item(CMD_STEP, coord_t'($urandom), coord_t'($urandom));
  endtask

  // cells climb under the full length, then the length drops below them
  task automatic test_length_lowered();
    wait_drain();
    write_reg(REG_RULE_LENGTH, 64'd64);
    repeat (8) send_item(CMD_STEP, coord_t'($urandom), coord_t'($urandom));
    wait_drain();
    write_reg(REG_RULE_LENGTH, 64'd2);
    repeat (3) send_item(CMD_STEP, coord_t'($urandom), coord_t'($urandom));
    send_item(CMD_READ, ant_px, ant_py);
  endtask

  task automatic test_random_short_rules();
    wait_drain();
    write_reg(REG_TURN_RULE, {$urandom, $urandom});
    write_reg(REG_RULE_LENGTH, 64'($urandom_range(2, 8)));
    run_walk(WalkItems);
  endtask

  task automatic test_all_right_full_length();
    wait_drain();
    write_reg(REG_TURN_RULE, '1);
    write_reg(REG_RULE_LENGTH, 64'd64);
    run_walk(WalkItems);
  endtask

  task automatic test_all_left_single_state();
    wait_drain();
    write_reg(REG_TURN_RULE, '0);
    write_reg(REG_RULE_LENGTH, 64'd1);
    run_walk(WalkItems);
  endtask

  // back-to-back beats, with the output held off long enough to fill the block
  task automatic test_long_output_stall();
    wait_drain();
    write_reg(REG_TURN_RULE, {$urandom, $urandom});
    write_reg(REG_RULE_LENGTH, {$urandom, $urandom});
    gaps_on = 1'b0;
    run_walk(WalkItems / 2);
    hold_request = 1'b1;
    run_walk(30);
    run_walk(WalkItems / 2 - 30);
    gaps_on = 1'b1;
  endtask

  // sender pauses mid-walk until every result is back
  task automatic test_sender_drain_pause();
    wait_drain();
    write_reg(REG_TURN_RULE, 64'hAAAA_AAAA_AAAA_AAAA);
    write_reg(REG_RULE_LENGTH, {$urandom, $urandom} | 64'h7F);
    run_walk(WalkItems / 2);
    wait_drain();
    run_walk(WalkItems - WalkItems / 2);
  endtask

  task automatic test_random_mid_length();
    wait_drain();
    write_reg(REG_TURN_RULE, {$urandom, $urandom});
    write_reg(REG_RULE_LENGTH, 64'($urandom_range(9, 64)));
    run_walk(WalkItems);
  endtask

  task automatic test_classic_rule_walk();
    wait_drain();
    write_reg(REG_TURN_RULE, 64'd2);
    write_reg(REG_RULE_LENGTH, 64'd2);
    run_walk(WalkItems);
  endtask

  initial begin
    foreach (grid_model[i]) grid_model[i] = '0;
    ant_px = CoordReset;
    ant_py = CoordReset;
    ant_dir = HEAD_NORTH;
    rule_bits = 64'd2;
    rule_len_reg = 7'd2;
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;

    test_cleared_grid_reads();
    test_classic_steps();
    test_length_zero();
    test_length_oversize();
    test_length_lowered();
    test_random_short_rules();
    test_all_right_full_length();
    test_all_left_single_state();
    test_long_output_stall();
    test_sender_drain_pause();
    test_random_mid_length();
    test_classic_rule_walk();
    wait_drain();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // receiver ready pattern, with an occasional long hold-off on request
  initial begin : receiver_pattern
    stall_mode_t mode;
    int          mode_left;
    mode = READY_ALWAYS;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = stall_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 150);
        end
        mode_left--;
        case (mode)
          READY_ALWAYS: m_axis_tready <= 1'b1;
          READY_HALF:   m_axis_tready <= ($urandom_range(0, 1) == 1);
          READY_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
          default:      m_axis_tready <= (mode_left % 5 != 0);
        endcase
      end
    end
  end

  // compare each output beat with the oldest prediction
  always @(posedge clk) begin : check_results
    ant_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: unexpected beat, expected none actual 0x%0h", $time, m_axis_tdata);
      end else begin
        want = expected_results.pop_front();
        check_field("ant_x", int'(want.x), int'(m_axis_tdata[CoordW-1:0]));
        check_field("ant_y", int'(want.y), int'(m_axis_tdata[2*CoordW-1:CoordW]));
        check_field("heading", int'(want.dir), int'(m_axis_tdata[2*CoordW+1:2*CoordW]));
        check_field("cell_value", int'(want.value),
                    int'(m_axis_tdata[2*CoordW+2+CellW-1:2*CoordW+2]));
      end
    end
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire
